FILE: src/bitmap_text_framebuffer_renderer_defines.svh
// Assertion shorthands for files that check their own logic.
`ifndef BITMAP_TEXT_FRAMEBUFFER_RENDERER_DEFINES_SVH
`define BITMAP_TEXT_FRAMEBUFFER_RENDERER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/btfr_pkg.sv
package btfr_pkg;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_CURSOR = 3'd1;
    localparam logic [2:0] OP_CHAR   = 3'd2;
    localparam logic [2:0] OP_FILL   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 8;
    localparam int CURSOR_STEP = 6;

    // One entry per code from 32 to 63, leftmost glyph column in the top byte.
    localparam logic [39:0] GLYPH_ROM [32] = '{
        40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
        40'h24_2A_7F_2A_12, 40'h62_64_08_13_23, 40'h36_49_56_20_50, 40'h00_08_07_00_00,
        40'h00_20_40_00_00, 40'h00_00_40_20_00, 40'h00_0A_7F_28_00, 40'h08_08_3E_08_08,
        40'h00_00_00_00_80, 40'h08_08_08_08_08, 40'h00_00_00_00_00, 40'h00_00_00_00_00,
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
        40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
        40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_00_36_36_00,
        40'h00_00_00_00_00, 40'h14_14_14_14_14, 40'h00_00_00_00_00, 40'h00_00_00_00_00
    };

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
        logic       fill_color;
        logic [7:0] char_code;
        logic [9:0] byte_address;
    } t_req;

    typedef struct packed {
        logic accept;
        logic sweep_start;
        logic sweep_step;
        logic cursor_load;
        logic glyph_start;
        logic mask_start;
        logic mask_step;
        logic fill_start;
        logic col_start;
        logic page_read;
        logic page_write;
        logic page_next;
        logic col_next;
        logic cursor_advance;
        logic read_issue;
        logic result_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       sweep_last;
        logic       mask_last;
        logic       byte_nz;
        logic       page_last;
        logic       col_on;
        logic       col_last;
        logic       sx_last;
        logic       fill_empty;
        logic       out_free;
    } t_sts;

    function automatic logic [7:0] glyph_column(input logic [7:0] code, input logic [2:0] col);
        logic [39:0] bits;
        logic [7:0]  res;
        bits = (code[7:5] == 3'b001) ? GLYPH_ROM[code[4:0]] : 40'h0;
        case (col)
            3'd0:    res = bits[39:32];
            3'd1:    res = bits[31:24];
            3'd2:    res = bits[23:16];
            3'd3:    res = bits[15:8];
            3'd4:    res = bits[7:0];
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

FILE: src/btfr_ifs.sv
interface btfr_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic       fill_color;
    logic [7:0] char_code;
    logic [9:0] byte_address;

    modport source (
        output valid, operation, x_pos, y_pos, rect_width, rect_height,
               fill_color, char_code, byte_address,
        input  ready
    );
    modport sink (
        input  valid, operation, x_pos, y_pos, rect_width, rect_height,
               fill_color, char_code, byte_address,
        output ready
    );
endinterface

interface btfr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;

    modport source (output valid, read_data, cursor_col, cursor_row, input ready);
    modport sink (input valid, read_data, cursor_col, cursor_row, output ready);
endinterface

FILE: src/btfr_ctrl.sv
module btfr_ctrl
    import btfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_CLR   = 4'd3;
    localparam logic [3:0] S_GMASK = 4'd4;
    localparam logic [3:0] S_FCHK  = 4'd5;
    localparam logic [3:0] S_COL   = 4'd6;
    localparam logic [3:0] S_PAGE  = 4'd7;
    localparam logic [3:0] S_WR    = 4'd8;
    localparam logic [3:0] S_CNEXT = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.op)
                    OP_CLEAR: begin
                        o_cmd.sweep_start = 1'b1;
                        n_state           = S_CLR;
                    end
                    OP_CURSOR: begin
                        o_cmd.cursor_load = 1'b1;
                        n_state           = S_DONE;
                    end
                    OP_CHAR: begin
                        o_cmd.glyph_start = 1'b1;
                        o_cmd.mask_start  = 1'b1;
                        n_state           = S_GMASK;
                    end
                    OP_FILL: begin
                        o_cmd.fill_start = 1'b1;
                        n_state          = S_FCHK;
                    end
                    OP_READ: begin
                        o_cmd.read_issue = 1'b1;
                        n_state          = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_CLR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) n_state = S_DONE;
            end
            S_GMASK: begin
                o_cmd.mask_step = 1'b1;
                if (i_sts.mask_last) n_state = S_COL;
            end
            S_FCHK: begin
                n_state = i_sts.fill_empty ? S_DONE : S_COL;
            end
            S_COL: begin
                if (i_sts.col_on) begin
                    o_cmd.col_start = 1'b1;
                    n_state         = S_PAGE;
                end else begin
                    n_state = S_CNEXT;
                end
            end
            S_PAGE: begin
                if (i_sts.byte_nz) begin
                    o_cmd.page_read = 1'b1;
                    n_state         = S_WR;
                end else if (i_sts.page_last) begin
                    n_state = S_CNEXT;
                end else begin
                    o_cmd.page_next = 1'b1;
                end
            end
            S_WR: begin
                o_cmd.page_write = 1'b1;
                if (i_sts.page_last) begin
                    n_state = S_CNEXT;
                end else begin
                    o_cmd.page_next = 1'b1;
                    n_state         = S_PAGE;
                end
            end
            S_CNEXT: begin
                if (i_sts.col_last) begin
                    o_cmd.cursor_advance = (i_sts.op == OP_CHAR);
                    n_state              = S_DONE;
                end else begin
                    o_cmd.col_next = 1'b1;
                    if (i_sts.op == OP_CHAR && i_sts.sx_last) begin
                        o_cmd.mask_start = 1'b1;
                        n_state          = S_GMASK;
                    end else begin
                        n_state = S_COL;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: src/btfr_dp.sv
module btfr_dp
    import btfr_pkg::*;
#(
    parameter int SCREEN_COLS = 128,
    parameter int SCREEN_ROWS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  t_req       i_req,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_read_data,
    output logic [7:0] o_cursor_col,
    output logic [7:0] o_cursor_row
);

    localparam int PAGE_COUNT  = (SCREEN_ROWS + 7) / 8;
    localparam int STORE_BYTES = SCREEN_COLS * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PG_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int MASK_W      = PAGE_COUNT * 8;

    logic [7:0]        r_mem [STORE_BYTES];
    logic [7:0]        r_rdata;

    logic [3:0]        r_scale;
    logic [7:0]        r_col;
    logic [7:0]        r_row;
    logic [ADDR_W-1:0] r_sw;
    logic              r_ovalid;

    logic [2:0]        r_op;
    logic [7:0]        r_x;
    logic [7:0]        r_y;
    logic [7:0]        r_w;
    logic [7:0]        r_h;
    logic              r_white;
    logic [7:0]        r_code;
    logic [9:0]        r_baddr;

    logic [7:0]        r_cc;
    logic [8:0]        r_xe;
    logic [2:0]        r_gi;
    logic [3:0]        r_sx;
    logic [2:0]        r_j;
    logic [7:0]        r_rstart;
    logic [MASK_W-1:0] r_vmask;
    logic [PG_W-1:0]   r_page;
    logic [ADDR_W-1:0] r_pbase;

    logic [7:0]        r_odata;
    logic [7:0]        r_ocol;
    logic [7:0]        r_orow;

    logic [3:0]        w_s;
    logic              w_sx_last;
    logic              w_baddr_ok;
    logic [7:0]        w_gbits;
    logic [7:0]        w_mbyte;
    logic [MASK_W-1:0] w_run;
    logic [MASK_W-1:0] w_fmask;
    logic [8:0]        w_ye;
    logic [8:0]        w_xsum;
    logic [8:0]        w_xe;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [ADDR_W-1:0] w_wa;
    logic [ADDR_W-1:0] w_ra;
    logic [7:0]        w_wd;
    logic [7:0]        w_rmw;

    assign w_s        = (r_scale == 4'd0) ? 4'd1 : r_scale;
    assign w_sx_last  = (r_sx == w_s - 4'd1);
    assign w_baddr_ok = ({22'd0, r_baddr} < 32'(STORE_BYTES));
    assign w_gbits    = glyph_column(r_code, r_gi);
    assign w_mbyte    = r_vmask[{r_page, 3'b000} +: 8];
    assign w_ye       = {1'b0, r_y} + {1'b0, r_h};
    assign w_xsum     = {1'b0, r_x} + {1'b0, r_w};
    assign w_xe       = (w_xsum > 9'(SCREEN_COLS)) ? 9'(SCREEN_COLS) : w_xsum;

    always_comb begin
        logic [7:0] d;
        for (int r = 0; r < MASK_W; r++) begin
            d          = 8'(r) - r_rstart;
            w_run[r]   = (r < SCREEN_ROWS) && (d < 8'(w_s));
            w_fmask[r] = (r < SCREEN_ROWS) && (9'(r) >= {1'b0, r_y}) && (9'(r) < w_ye);
        end
    end

    assign w_rmw    = (r_op == OP_CHAR || r_white) ? (r_rdata | w_mbyte) : (r_rdata & ~w_mbyte);
    assign w_mem_we = i_cmd.sweep_step | i_cmd.page_write;
    assign w_wa     = i_cmd.sweep_step ? r_sw : r_pbase;
    assign w_wd     = i_cmd.sweep_step ? 8'h00 : w_rmw;
    assign w_mem_re = i_cmd.page_read | (i_cmd.read_issue & w_baddr_ok);
    assign w_ra     = i_cmd.read_issue ? ADDR_W'(r_baddr) : r_pbase;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_wa] <= w_wd;
        if (w_mem_re) r_rdata <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 4'd1;
            r_col    <= 8'd0;
            r_row    <= 8'd0;
            r_sw     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_scale <= i_cfg_wdata;
            if (i_cmd.cursor_load) begin
                r_col <= r_x;
                r_row <= r_y;
            end else if (i_cmd.cursor_advance) begin
                r_col <= r_col + 8'(w_s) * 8'(CURSOR_STEP);
            end
            if (i_cmd.sweep_start) begin
                r_sw <= '0;
            end else if (i_cmd.sweep_step) begin
                r_sw <= r_sw + ADDR_W'(1);
            end
            if (i_cmd.result_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_req.operation;
            r_x     <= i_req.x_pos;
            r_y     <= i_req.y_pos;
            r_w     <= i_req.rect_width;
            r_h     <= i_req.rect_height;
            r_white <= i_req.fill_color;
            r_code  <= i_req.char_code;
            r_baddr <= i_req.byte_address;
        end
        if (i_cmd.fill_start) begin
            r_cc    <= r_x;
            r_xe    <= w_xe;
            r_vmask <= w_fmask;
        end
        if (i_cmd.glyph_start) begin
            r_cc <= r_col;
            r_gi <= 3'd0;
            r_sx <= 4'd0;
        end
        if (i_cmd.mask_start) begin
            r_vmask  <= '0;
            r_j      <= 3'd0;
            r_rstart <= r_row;
        end
        if (i_cmd.mask_step) begin
            if (w_gbits[r_j]) r_vmask <= r_vmask | w_run;
            r_j      <= r_j + 3'd1;
            r_rstart <= r_rstart + 8'(w_s);
        end
        if (i_cmd.col_start) begin
            r_page  <= '0;
            r_pbase <= ADDR_W'(r_cc);
        end
        if (i_cmd.page_next) begin
            r_page  <= r_page + PG_W'(1);
            r_pbase <= r_pbase + ADDR_W'(SCREEN_COLS);
        end
        if (i_cmd.col_next) begin
            r_cc <= r_cc + 8'd1;
            if (w_sx_last) begin
                r_sx <= 4'd0;
                r_gi <= r_gi + 3'd1;
            end else begin
                r_sx <= r_sx + 4'd1;
            end
        end
        if (i_cmd.result_load) begin
            r_odata <= (r_op == OP_READ && w_baddr_ok) ? r_rdata : 8'h00;
            r_ocol  <= r_col;
            r_orow  <= r_row;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.sweep_last = (r_sw == ADDR_W'(STORE_BYTES - 1));
        o_sts.mask_last  = (r_j == 3'(GLYPH_ROWS - 1));
        o_sts.byte_nz    = (w_mbyte != 8'h00);
        o_sts.page_last  = (r_page == PG_W'(PAGE_COUNT - 1));
        o_sts.col_on     = ({1'b0, r_cc} < 9'(SCREEN_COLS));
        o_sts.sx_last    = w_sx_last;
        o_sts.col_last   = (r_op == OP_CHAR) ? (r_gi == 3'(GLYPH_COLS - 1) && w_sx_last)
                                             : ({1'b0, r_cc} + 9'd1 >= r_xe);
        o_sts.fill_empty = ({1'b0, r_cc} >= r_xe) || (r_vmask == '0);
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

    assign o_out_valid  = r_ovalid;
    assign o_read_data  = r_odata;
    assign o_cursor_col = r_ocol;
    assign o_cursor_row = r_orow;

endmodule

FILE: src/bitmap_text_framebuffer_renderer.sv
// Monochrome text framebuffer with 8-pixel vertical pages, held in one on-chip memory.
// Requests arrive on i_req (valid/ready); each gives exactly one response on o_rsp
// carrying the read byte (zero unless a read) and the text cursor after the request.
// The user must write the text scale register through i_cfg_we/i_cfg_wdata only while
// the block is idle; the block itself does not enforce this.
// A clear writes one memory byte per cycle. A printed char builds the row mask of each
// glyph column from its 8 rows, then visits every page of each screen column it covers;
// a fill rect visits every page of each column in the box. Each lit page costs a read
// and a write of the memory.
// One request is processed at a time; the next is taken as soon as the response
// has been placed in the output register, even if it has not yet been taken.
// After reset the memory is cleared, one byte per cycle, all SCREEN_COLS * pages bytes
// (1024 at the default size), before the first request is accepted.
// When the receiver stalls, the response waits in the output register and the
// following request stops just before it would write its own response.
`include "bitmap_text_framebuffer_renderer_defines.svh"

module bitmap_text_framebuffer_renderer
    import btfr_pkg::*;
#(
    parameter int SCREEN_COLS = 128,
    parameter int SCREEN_ROWS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    btfr_req_if.sink        i_req,
    btfr_rsp_if.source      o_rsp,
    input  logic            i_cfg_we,
    input  logic [3:0]      i_cfg_wdata
);

    t_cmd w_cmd;
    t_sts w_sts;
    t_req w_req;
    logic w_in_ready;

    assign w_req.operation    = i_req.operation;
    assign w_req.x_pos        = i_req.x_pos;
    assign w_req.y_pos        = i_req.y_pos;
    assign w_req.rect_width   = i_req.rect_width;
    assign w_req.rect_height  = i_req.rect_height;
    assign w_req.fill_color   = i_req.fill_color;
    assign w_req.char_code    = i_req.char_code;
    assign w_req.byte_address = i_req.byte_address;
    assign i_req.ready        = w_in_ready;

    btfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    btfr_dp #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (w_req),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_read_data  (o_rsp.read_data),
        .o_cursor_col (o_rsp.cursor_col),
        .o_cursor_row (o_rsp.cursor_row)
    );

    `BTFR_ASSERT_NEXT(a_busy_after_accept, w_cmd.accept, !w_in_ready, "request taken while busy")
    `BTFR_ASSERT_IMP(a_load_when_free, w_cmd.result_load, w_sts.out_free, "response overwritten")
    `BTFR_ASSERT_IMP(a_write_after_read, w_cmd.page_write, $past(w_cmd.page_read), "write without read")

endmodule

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import btfr_pkg::*;

    localparam int COLS        = 128;
    localparam int ROWS        = 64;
    localparam int PAGES       = (ROWS + 7) / 8;
    localparam int STORE_BYTES = COLS * PAGES;
    localparam int FONT_FIRST  = 32;
    localparam int FONT_COUNT  = 32;
    localparam int PEN_STEP    = 6;

    localparam logic [2:0] OP_SPARE_FIRST = OP_READ + 3'd1;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_ITEMS   = 100;

    // Leftmost glyph column in the top byte; bit 0 of a column is its top row.
    localparam logic [39:0] FONT_COLS [FONT_COUNT] = '{
        40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
        40'h24_2A_7F_2A_12, 40'h62_64_08_13_23, 40'h36_49_56_20_50, 40'h00_08_07_00_00,
        40'h00_20_40_00_00, 40'h00_00_40_20_00, 40'h00_0A_7F_28_00, 40'h08_08_3E_08_08,
        40'h00_00_00_00_80, 40'h08_08_08_08_08, 40'h00_00_00_00_00, 40'h00_00_00_00_00,
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
        40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
        40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_00_36_36_00,
        40'h00_00_00_00_00, 40'h14_14_14_14_14, 40'h00_00_00_00_00, 40'h00_00_00_00_00
    };

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
    } t_screen_reply;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_wdata;

    btfr_req_if cmd_bus ();
    btfr_rsp_if reply_bus ();

    bitmap_text_framebuffer_renderer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (cmd_bus),
        .o_rsp       (reply_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    logic [7:0]    pixels [STORE_BYTES];
    logic [7:0]    pen_col;
    logic [7:0]    pen_row;
    logic [3:0]    pen_scale;
    t_screen_reply expected_replies [$];
    int            failures;
    int            cycles;
    int            burst_left;

    function automatic void plot(int c, int r, bit white);
        if (c >= COLS || r >= ROWS) begin
            return;
        end
        pixels[c + (r / 8) * COLS][r % 8] = white;
    endfunction

    function automatic void draw_glyph(logic [7:0] code);
        int          s;
        logic [39:0] cols;
        logic [7:0]  bits;
        s = (pen_scale == 4'd0) ? 1 : int'(pen_scale);
        if (code >= FONT_FIRST && code < FONT_FIRST + FONT_COUNT) begin
            cols = FONT_COLS[code - FONT_FIRST];
            for (int i = 0; i < 5; i++) begin
                bits = cols[39 - 8 * i -: 8];
                for (int j = 0; j < 8; j++) begin
                    if (bits[j]) begin
                        for (int sx = 0; sx < s; sx++) begin
                            for (int sy = 0; sy < s; sy++) begin
                                plot((int'(pen_col) + i * s + sx) & 255,
                                     (int'(pen_row) + j * s + sy) & 255, 1'b1);
                            end
                        end
                    end
                end
            end
        end
        pen_col = 8'((int'(pen_col) + PEN_STEP * s) & 255);
    endfunction

    function automatic void fill_box(int x, int y, int w, int h, bit white);
        int xe;
        int ye;
        xe = (x + w > COLS) ? COLS : x + w;
        ye = (y + h > ROWS) ? ROWS : y + h;
        for (int c = x; c < xe; c++) begin
            for (int r = y; r < ye; r++) begin
                plot(c, r, white);
            end
        end
    endfunction

    function automatic t_screen_reply render_command(t_req r);
        t_screen_reply e;
        e.read_data = 8'h00;
        case (r.operation)
            OP_CLEAR: begin
                foreach (pixels[k]) pixels[k] = 8'h00;
            end
            OP_CURSOR: begin
                pen_col = r.x_pos;
                pen_row = r.y_pos;
            end
            OP_CHAR: begin
                draw_glyph(r.char_code);
            end
            OP_FILL: begin
                fill_box(int'(r.x_pos), int'(r.y_pos), int'(r.rect_width),
                         int'(r.rect_height), r.fill_color);
            end
            OP_READ: begin
                if (r.byte_address < STORE_BYTES) e.read_data = pixels[r.byte_address];
            end
            default: begin
            end
        endcase
        e.cursor_col = pen_col;
        e.cursor_row = pen_row;
        return e;
    endfunction

    function automatic t_req command(logic [2:0] op, logic [7:0] x, logic [7:0] y,
                                     logic [7:0] w, logic [7:0] h, logic color,
                                     logic [7:0] code, logic [9:0] addr);
        t_req r;
        r.operation    = op;
        r.x_pos        = x;
        r.y_pos        = y;
        r.rect_width   = w;
        r.rect_height  = h;
        r.fill_color   = color;
        r.char_code    = code;
        r.byte_address = addr;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none at all.
    function automatic int pick_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(19, 0) == 0) begin
            burst_left = $urandom_range(60, 20);
            return 0;
        end
        case ($urandom_range(9, 0))
            0, 1, 2, 3, 4, 5: return 0;
            6, 7, 8:          return $urandom_range(3, 1);
            default:          return $urandom_range(40, 5);
        endcase
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        r = command(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom), 8'($urandom), 10'($urandom));
        pick = $urandom_range(99, 0);
        if (pick < 2) begin
            r.operation = OP_CLEAR;
        end else if (pick < 16) begin
            r.operation = OP_CURSOR;
            if ($urandom_range(4, 0) != 0) begin
                r.x_pos = 8'($urandom_range(COLS - 1, 0));
                r.y_pos = 8'($urandom_range(ROWS - 1, 0));
            end
        end else if (pick < 50) begin
            r.operation = OP_CHAR;
            if ($urandom_range(6, 0) != 0) begin
                r.char_code = 8'($urandom_range(FONT_FIRST + FONT_COUNT - 1, FONT_FIRST));
            end
        end else if (pick < 66) begin
            r.operation = OP_FILL;
            if ($urandom_range(9, 0) != 0) begin
                r.x_pos       = 8'($urandom_range(COLS + 7, 0));
                r.y_pos       = 8'($urandom_range(ROWS + 7, 0));
                r.rect_width  = 8'($urandom_range(24, 0));
                r.rect_height = 8'($urandom_range(24, 0));
            end
        end else if (pick < 94) begin
            r.operation = OP_READ;
        end else begin
            r.operation = 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        end
        return r;
    endfunction

    task automatic issue_command(t_req r);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            cmd_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_bus.operation    = r.operation;
        cmd_bus.x_pos        = r.x_pos;
        cmd_bus.y_pos        = r.y_pos;
        cmd_bus.rect_width   = r.rect_width;
        cmd_bus.rect_height  = r.rect_height;
        cmd_bus.fill_color   = r.fill_color;
        cmd_bus.char_code    = r.char_code;
        cmd_bus.byte_address = r.byte_address;
        cmd_bus.valid        = 1'b1;
        do @(posedge clk); while (!cmd_bus.ready);
        expected_replies.push_back(render_command(r));
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_bus.valid = 1'b0;
        while (expected_replies.size() != 0) @(posedge clk);
    endtask

    task automatic set_scale(logic [3:0] value);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        pen_scale = value;
    endtask

    task automatic run_random(int count);
        repeat (count) issue_command(random_request());
    endtask

    task automatic check_reset_state();
        issue_command(command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0));
        issue_command(command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd1023));
        issue_command(command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd517));
    endtask

    task automatic check_cursor_and_spare_codes();
        issue_command(command(OP_CURSOR, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0));
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
            issue_command(command(3'(op), 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255,
                                  10'd1023));
        end
        issue_command(command(OP_CURSOR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0));
    endtask

    task automatic check_glyph_drawing();
        issue_command(command(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd48, 10'd0));
        issue_command(command(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd44, 10'd0));
        issue_command(command(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd31, 10'd0));
        issue_command(command(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd64, 10'd0));
        issue_command(command(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd255, 10'd0));
        issue_command(command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd1));
        issue_command(command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd138));
        issue_command(command(OP_CURSOR, 8'd124, 8'd60, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0));
        issue_command(command(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd35, 10'd0));
        issue_command(command(OP_CURSOR, 8'd253, 8'd252, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0));
        issue_command(command(OP_CHAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd56, 10'd0));
        issue_command(command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd1));
    endtask

    task automatic check_rect_fill();
        issue_command(command(OP_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 8'd0, 10'd0));
        issue_command(command(OP_FILL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 10'd0));
        issue_command(command(OP_FILL, 8'd10, 8'd3, 8'd0, 8'd5, 1'b0, 8'd0, 10'd0));
        issue_command(command(OP_FILL, 8'd10, 8'd3, 8'd20, 8'd30, 1'b0, 8'd0, 10'd0));
        issue_command(command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd10));
        issue_command(command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd1023));
        issue_command(command(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd0));
        issue_command(command(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 10'd1023));
    endtask

    task automatic check_scale_settings();
        logic [3:0] scales [5] = '{4'd0, 4'd2, 4'd8, 4'd15, 4'd3};
        run_random(PHASE_ITEMS);
        foreach (scales[k]) begin
            set_scale(scales[k]);
            run_random(PHASE_ITEMS);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // The receiver holds off in stretches of random length, with long open runs now and then.
    initial begin
        int open_left;
        int stall_left;
        open_left  = 0;
        stall_left = 0;
        reply_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (open_left > 0) begin
                reply_bus.ready = 1'b1;
                open_left--;
            end else if (stall_left > 0) begin
                reply_bus.ready = 1'b0;
                stall_left--;
            end else begin
                open_left  = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 50)
                                                         : $urandom_range(6, 0);
                stall_left = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 10)
                                                         : $urandom_range(3, 0);
                reply_bus.ready = 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        t_screen_reply want;
        if (rst_n && reply_bus.valid && reply_bus.ready) begin
            if (expected_replies.size() == 0) begin
                $error("response with no request outstanding");
                failures++;
            end else begin
                want = expected_replies.pop_front();
                if (reply_bus.read_data !== want.read_data) begin
                    $error("read_data: expected %0d, got %0d", want.read_data,
                           reply_bus.read_data);
                    failures++;
                end
                if (reply_bus.cursor_col !== want.cursor_col) begin
                    $error("cursor_col: expected %0d, got %0d", want.cursor_col,
                           reply_bus.cursor_col);
                    failures++;
                end
                if (reply_bus.cursor_row !== want.cursor_row) begin
                    $error("cursor_row: expected %0d, got %0d", want.cursor_row,
                           reply_bus.cursor_row);
                    failures++;
                end
            end
        end
    end

    initial begin
        failures   = 0;
        cycles     = 0;
        burst_left = 0;
        pen_col    = 8'd0;
        pen_row    = 8'd0;
        pen_scale  = 4'd1;
        foreach (pixels[k]) pixels[k] = 8'h00;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = 4'd0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.operation    = OP_CLEAR;
        cmd_bus.x_pos        = 8'd0;
        cmd_bus.y_pos        = 8'd0;
        cmd_bus.rect_width   = 8'd0;
        cmd_bus.rect_height  = 8'd0;
        cmd_bus.fill_color   = 1'b0;
        cmd_bus.char_code    = 8'd0;
        cmd_bus.byte_address = 10'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_reset_state();
        check_cursor_and_spare_codes();
        check_glyph_drawing();
        check_rect_fill();
        check_scale_settings();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
